@@ hdl/assert_macros.svh @@
// assertion macros shared by the interpolation block
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hdl/plin_pkg.sv @@
// types and constants of the piecewise linear interpolation block
// no dependencies; used by the top level, the divider and the testbench
`timescale 1ns / 1ps

package plin_pkg;

   localparam int MAX_POINTS = 64;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int CNT_W      = 7;
   localparam int SEG_W      = 6;
   localparam int FRAC_W     = 16;
   localparam int DIV_STEPS  = FRAC_W + 1;
   localparam int STEP_W     = $clog2(DIV_STEPS + 1);

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic               op;
      logic [5:0]         entry_index;
      logic signed [15:0] x_value;
      logic signed [15:0] y_value;
      logic signed [15:0] query_point;
   } plin_req_type;

   typedef struct packed {
      logic signed [15:0] result_value;
      logic               in_range;
      logic [5:0]         segment_found;
   } plin_rsp_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
   } plin_entry_type;

   localparam int ENTRY_W = $bits(plin_entry_type);

endpackage

@@ hdl/piecewise_linear_interpolation.sv @@
// top level of the piecewise linear interpolation block
// depends on plin_pkg, plin_ram, plin_div and assert_macros.svh
// ---------------------------------------------------------------------------
// Breakpoint table lookup with linear interpolation. A load request (op 0)
// writes one {x, y} breakpoint into a 64-entry ram and answers at once with
// an all-zero response. A query request (op 1) walks the segments (k, k+1)
// in order, one table read per cycle, and uses the first segment whose ends
// bracket the point in either order. The fraction mu = |p-x[k]|/|x[k+1]-x[k]|
// is formed by a bit-serial divider (16 fraction bits plus the whole bit),
// then one 17x18 multiply and an add give
// y[k] + floor((y[k+1]-y[k])*mu / 65536). A zero-length segment answers y[k].
// A query that finds no segment answers zero with in_range low. The block
// takes one request at a time. A query with fewer than two points in use
// misses without a table read. The scan is bound by the single ram read port
// and the fraction by the divider. The response sits in an output register,
// and no new request is taken while a response waits there under stall.
// The user must write point_count through csr_ only while the block is idle;
// the block itself does not enforce this. Values above 64 act as 64. Table
// entries read before being loaded give undefined results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module piecewise_linear_interpolation (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  plin_pkg::plin_req_type req_data,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output plin_pkg::plin_rsp_type rsp_data,
   // point count register
   input  logic                   csr_wr_en,
   input  logic [6:0]             csr_wr_data
);

   // one-hot sequencer states
   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,   // waiting for a request
      S_FIRST = 6'b000010,   // entry 0 arriving from the ram
      S_SCAN  = 6'b000100,   // entry k+1 arriving, test segment k
      S_DIV   = 6'b001000,   // divider running
      S_MUL   = 6'b010000,   // multiply slope by fraction
      S_DONE  = 6'b100000    // hand response to the output register
   } state_type;

   state_type                          state_ff, state_in;
   logic [plin_pkg::CNT_W-1:0]         csr_ff, csr_in;
   logic [plin_pkg::ADDR_W-1:0]        k_ff, k_in;
   logic signed [15:0]                 xa_ff, xa_in;
   logic signed [15:0]                 ya_ff, ya_in;
   logic signed [15:0]                 p_ff, p_in;
   logic signed [16:0]                 dy_ff, dy_in;
   logic                               den_zero_ff, den_zero_in;
   logic                               hit_ff, hit_in;
   logic signed [34:0]                 prod_ff, prod_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   plin_pkg::plin_rsp_type             rsp_data_ff, rsp_data_in;

   logic                               req_take;
   logic                               rsp_take;
   logic                               out_free;
   logic [plin_pkg::CNT_W-1:0]         count_sat;
   logic [plin_pkg::ADDR_W:0]          kp2;

   // table ram
   logic                               ram_wr_en;
   logic [plin_pkg::ADDR_W-1:0]        ram_rd_addr;
   plin_pkg::plin_entry_type           ram_wr_data;
   plin_pkg::plin_entry_type           ram_rd_data;
   logic [plin_pkg::ENTRY_W-1:0]       ram_rd_bits;

   // segment test
   logic signed [15:0]                 xb;
   logic signed [15:0]                 yb;
   logic                               bracket;
   logic signed [16:0]                 dpx;
   logic signed [16:0]                 dbx;
   logic [15:0]                        num;
   logic [15:0]                        den;

   // divider and final add
   logic                               div_start;
   logic                               div_done;
   logic [plin_pkg::FRAC_W:0]          quotient;
   logic [plin_pkg::FRAC_W:0]          mu;
   logic signed [plin_pkg::FRAC_W+1:0] mu_s;
   logic signed [18:0]                 scaled;
   logic signed [18:0]                 sum;

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;

   assign count_sat = (csr_ff > plin_pkg::CNT_W'(plin_pkg::MAX_POINTS))
                    ? plin_pkg::CNT_W'(plin_pkg::MAX_POINTS) : csr_ff;

   // address of the entry after the one arriving now
   assign kp2 = {1'b0, k_ff} + (plin_pkg::ADDR_W + 1)'(2);

   assign ram_wr_en   = req_take && (req_data.op == plin_pkg::OP_LOAD)
                        && (32'(req_data.entry_index) < plin_pkg::MAX_POINTS);
   assign ram_wr_data = '{x: req_data.x_value, y: req_data.y_value};

   always_comb begin
      case (state_ff)
         S_FIRST: ram_rd_addr = plin_pkg::ADDR_W'(1);
         S_SCAN:  ram_rd_addr = kp2[plin_pkg::ADDR_W-1:0];
         default: ram_rd_addr = '0;
      endcase
   end

   plin_ram #(
      .WIDTH (plin_pkg::ENTRY_W),
      .DEPTH (plin_pkg::MAX_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (plin_pkg::ADDR_W'(req_data.entry_index)),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   assign ram_rd_data = ram_rd_bits;
   assign xb = ram_rd_data.x;
   assign yb = ram_rd_data.y;

   // ends included, either orientation
   assign bracket = ((xa_ff <= p_ff) && (xb >= p_ff)) || ((xa_ff >= p_ff) && (xb <= p_ff));

   // magnitudes fit 16 bits unsigned
   assign dpx = 17'(p_ff) - 17'(xa_ff);
   assign dbx = 17'(xb) - 17'(xa_ff);
   assign num = dpx[16] ? 16'(-dpx) : dpx[15:0];
   assign den = dbx[16] ? 16'(-dbx) : dbx[15:0];

   assign div_start = (state_ff == S_SCAN) && bracket;

   plin_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (num),
      .den      (den),
      .done     (div_done),
      .quotient (quotient)
   );

   // zero-length segment: fraction zero gives y[k]
   assign mu      = den_zero_ff ? '0 : quotient;
   assign mu_s    = $signed({1'b0, mu});
   assign prod_in = dy_ff * mu_s;

   // arithmetic shift floors toward minus infinity
   assign scaled = $signed(prod_ff[34:16]);
   assign sum    = 19'(ya_ff) + scaled;

   always_comb begin
      state_in     = state_ff;
      csr_in       = csr_ff;
      k_in         = k_ff;
      xa_in        = xa_ff;
      ya_in        = ya_ff;
      p_in         = p_ff;
      dy_in        = dy_ff;
      den_zero_in  = den_zero_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      rsp_data_in  = rsp_data_ff;

      if (csr_wr_en) begin
         csr_in = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_data.op == plin_pkg::OP_LOAD) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
               end else begin
                  p_in   = req_data.query_point;
                  hit_in = 1'b0;
                  k_in   = '0;
                  if (count_sat < plin_pkg::CNT_W'(2)) begin
                     state_in = S_DONE;
                  end else begin
                     state_in = S_FIRST;
                  end
               end
            end
         end
         S_FIRST: begin
            xa_in    = ram_rd_data.x;
            ya_in    = ram_rd_data.y;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (bracket) begin
               hit_in      = 1'b1;
               dy_in       = 17'(yb) - 17'(ya_ff);
               den_zero_in = (den == '0);
               state_in    = S_DIV;
            end else if (kp2 < count_sat) begin
               k_in  = k_ff + plin_pkg::ADDR_W'(1);
               xa_in = xb;
               ya_in = yb;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (hit_ff) begin
                  rsp_data_in.result_value  = sum[15:0];
                  rsp_data_in.in_range      = 1'b1;
                  rsp_data_in.segment_found = plin_pkg::SEG_W'(k_ff);
               end else begin
                  rsp_data_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         csr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_ff       <= csr_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
      end
      k_ff        <= k_in;
      xa_ff       <= xa_in;
      ya_ff       <= ya_in;
      p_ff        <= p_in;
      dy_ff       <= dy_in;
      den_zero_ff <= den_zero_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_IMPLIES(a_state_onehot, clock, reset, 1'b1, $onehot(state_ff))
   `ASSERT_IMPLIES(a_scan_in_table, clock, reset, state_ff == S_SCAN, kp2 <= count_sat)
   `ASSERT_IMPLIES(a_div_done_state, clock, reset, div_done, state_ff == S_DIV)
   `ASSERT_IMPLIES(a_mul_after_div, clock, reset, state_ff == S_MUL, $past(div_done))

endmodule

@@ hdl/plin_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module plin_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/plin_div.sv @@
// restoring divider for the segment fraction, one quotient bit per cycle
// depends on plin_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module plin_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [15:0]                num,
   input  logic [15:0]                den,
   output logic                       done,
   output logic [plin_pkg::FRAC_W:0]  quotient
);

   logic                             busy_ff, busy_in;
   logic [plin_pkg::STEP_W-1:0]      cnt_ff, cnt_in;
   logic [16:0]                      rem_ff, rem_in;
   logic [15:0]                      den_ff, den_in;
   logic [plin_pkg::FRAC_W:0]        q_ff, q_in;
   logic                             fits;
   logic [16:0]                      rem_sub;

   // num <= den, so the partial remainder stays below twice den
   assign fits    = rem_ff >= {1'b0, den_ff};
   assign rem_sub = fits ? (rem_ff - {1'b0, den_ff}) : rem_ff;
   assign done    = busy_ff && (cnt_ff == plin_pkg::STEP_W'(1));

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = plin_pkg::STEP_W'(plin_pkg::DIV_STEPS);
         rem_in  = {1'b0, num};
         den_in  = den;
         q_in    = '0;
      end else if (busy_ff) begin
         cnt_in  = cnt_ff - plin_pkg::STEP_W'(1);
         rem_in  = {rem_sub[15:0], 1'b0};
         q_in    = {q_ff[plin_pkg::FRAC_W-1:0], fits};
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign quotient = q_ff;

   `ASSERT_IMPLIES(a_busy_count, clock, reset, busy_ff, cnt_ff != '0)
   `ASSERT_NEXT(a_done_idle, clock, reset, done && !start, !busy_ff)
   `ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff)

endmodule

@@ tb/piecewise_linear_interpolation_tb.sv @@
// self-checking testbench for the piecewise linear interpolation block
// depends on plin_pkg and piecewise_linear_interpolation; holds its own
// interpolation predictor in a small scoreboard class and drives both channels
`timescale 1ns / 1ps

module piecewise_linear_interpolation_tb;

   localparam int CYCLE_LIMIT = 800_000;

   // breakpoint layouts loaded at the start of a random phase
   typedef enum {
      SHAPE_RISING,
      SHAPE_FALLING,
      SHAPE_PLATEAU,
      SHAPE_SCRAMBLED,
      SHAPE_EXTREME
   } table_shape_type;

   // ------------------------------------------------------------------------
   // scoreboard: mirrors the breakpoint table and the point count, turns each
   // accepted request into its expected response and checks responses in order
   // ------------------------------------------------------------------------
   class interp_scoreboard;
      logic signed [15:0]     x_tab [plin_pkg::MAX_POINTS];
      logic signed [15:0]     y_tab [plin_pkg::MAX_POINTS];
      int unsigned            point_count;
      plin_pkg::plin_rsp_type expected_answers [$];
      int                     failures;

      function new();
         for (int i = 0; i < plin_pkg::MAX_POINTS; i++) begin
            x_tab[i] = '0;
            y_tab[i] = '0;
         end
         point_count = 0;
         failures    = 0;
      endfunction

      // first bracketing segment wins, ends included, in either direction
      function plin_pkg::plin_rsp_type interpolate(input logic signed [15:0] p);
         plin_pkg::plin_rsp_type ans;
         longint                 pl, xa, xb, ya, yb, num, den, mu, r;
         int                     lim;
         int                     k;
         ans = '0;
         pl  = p;
         lim = (point_count > plin_pkg::MAX_POINTS) ? plin_pkg::MAX_POINTS : point_count;
         for (k = 0; k + 1 < lim; k++) begin
            xa = x_tab[k];
            xb = x_tab[k + 1];
            if ((xa <= pl && xb >= pl) || (xa >= pl && xb <= pl)) begin
               ya  = y_tab[k];
               yb  = y_tab[k + 1];
               num = (pl >= xa) ? pl - xa : xa - pl;
               den = (xb >= xa) ? xb - xa : xa - xb;
               if (den == 0) begin
                  // zero-length segment answers its left ordinate
                  r = ya;
               end else begin
                  // truncated fraction, then a floored product (arith shift)
                  mu = (num * 65536) / den;
                  r  = ya + (((yb - ya) * mu) >>> 16);
               end
               ans.result_value  = r[15:0];
               ans.in_range      = 1'b1;
               ans.segment_found = k[5:0];
               return ans;
            end
         end
         return ans;
      endfunction

      function void note_request(input plin_pkg::plin_req_type item);
         if (item.op == plin_pkg::OP_LOAD) begin
            x_tab[item.entry_index] = item.x_value;
            y_tab[item.entry_index] = item.y_value;
            expected_answers.push_back('0);
         end else begin
            expected_answers.push_back(interpolate(item.query_point));
         end
      endfunction

      function void check_response(input plin_pkg::plin_rsp_type got);
         plin_pkg::plin_rsp_type want;
         if (expected_answers.size() == 0) begin
            failures++;
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            return;
         end
         want = expected_answers.pop_front();
         if (got.result_value !== want.result_value) begin
            failures++;
            $display("%0t: result_value expected %0d actual %0d",
                     $time, want.result_value, got.result_value);
         end
         if (got.in_range !== want.in_range) begin
            failures++;
            $display("%0t: in_range expected %b actual %b",
                     $time, want.in_range, got.in_range);
         end
         if (got.segment_found !== want.segment_found) begin
            failures++;
            $display("%0t: segment_found expected %0d actual %0d",
                     $time, want.segment_found, got.segment_found);
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // dut hookup
   // ------------------------------------------------------------------------
   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   plin_pkg::plin_req_type req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   plin_pkg::plin_rsp_type rsp_data;
   logic                   csr_wr_en;
   logic [6:0]             csr_wr_data;

   piecewise_linear_interpolation uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   interp_scoreboard   board;
   int                 req_idle_pct;   // chance of a gap before a request
   int                 rsp_idle_pct;   // chance of starting a stall burst
   int                 stall_left;
   logic signed [15:0] new_x [plin_pkg::MAX_POINTS];
   logic signed [15:0] new_y [plin_pkg::MAX_POINTS];

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("piecewise_linear_interpolation_tb failed");
      $finish;
   end

   // response side stalls in bursts of random length
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else if ($urandom_range(0, 99) < rsp_idle_pct) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // every accepted response goes to the scoreboard
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         board.check_response(rsp_data);
   end

   // ------------------------------------------------------------------------
   // request builders; fields a request does not use still carry random bits
   // ------------------------------------------------------------------------
   function automatic plin_pkg::plin_req_type load_item(input int idx, input int x,
                                                        input int y);
      plin_pkg::plin_req_type item;
      item.op          = plin_pkg::OP_LOAD;
      item.entry_index = 6'(idx);
      item.x_value     = 16'(x);
      item.y_value     = 16'(y);
      item.query_point = 16'($urandom);
      return item;
   endfunction

   function automatic plin_pkg::plin_req_type query_item(input int p);
      plin_pkg::plin_req_type item;
      item.op          = plin_pkg::OP_QUERY;
      item.entry_index = 6'($urandom);
      item.x_value     = 16'($urandom);
      item.y_value     = 16'($urandom);
      item.query_point = 16'(p);
      return item;
   endfunction

   // mostly queries aimed at live segments; some stray loads and wild points
   function automatic plin_pkg::plin_req_type next_item(input int lim);
      int pick;
      int k;
      int lo;
      int hi;
      int tmp;
      pick = $urandom_range(0, 99);
      if (pick < 10)
         return load_item($urandom_range(0, 63), $urandom, $urandom);
      if (lim < 2 || pick < 30)
         return query_item($urandom);
      if (pick < 38)
         return query_item($urandom_range(0, 1) ? 32767 : -32768);
      k  = $urandom_range(0, lim - 2);
      lo = board.x_tab[k];
      hi = board.x_tab[k + 1];
      if (lo > hi) begin
         tmp = lo;
         lo  = hi;
         hi  = tmp;
      end
      // segment ends exercise mu at zero and at its full-scale value
      if (pick < 55)
         return query_item($urandom_range(0, 1) ? lo : hi);
      return query_item(lo + int'($urandom_range(0, hi - lo)));
   endfunction

   // ------------------------------------------------------------------------
   // drivers: inputs move on the falling edge, handshakes sampled on the rising
   // ------------------------------------------------------------------------
   task automatic send_request(input plin_pkg::plin_req_type item);
      int gap;
      gap = ($urandom_range(0, 99) < req_idle_pct) ? $urandom_range(1, 5) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_request(item);
   endtask

   // register write only once the block has drained and every expected response
   // has been checked
   task automatic write_point_count(input logic [6:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.expected_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= 7'($urandom);
      board.point_count = value;
   endtask

   // one random phase: set the count, load a fresh table, then query it
   task automatic run_phase(input logic [6:0] cnt, input table_shape_type shape,
                            input int queries, input bit fill_all, input bit calm);
      int lim;
      int fill_n;
      int acc;
      int i;
      if (calm) begin
         req_idle_pct = 0;
         rsp_idle_pct = 0;
      end else begin
         req_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
         rsp_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
      end
      write_point_count(cnt);
      lim    = (cnt > plin_pkg::MAX_POINTS) ? plin_pkg::MAX_POINTS : cnt;
      fill_n = fill_all ? plin_pkg::MAX_POINTS : lim;

      acc = (shape == SHAPE_FALLING) ? 32767 - $urandom_range(0, 2000)
                                     : -32768 + $urandom_range(0, 2000);
      for (i = 0; i < plin_pkg::MAX_POINTS; i++) begin
         new_y[i] = 16'($urandom);
         case (shape)
            SHAPE_RISING: begin
               new_x[i] = 16'(acc);
               acc = acc + $urandom_range(0, 1000);
            end
            SHAPE_FALLING: begin
               new_x[i] = 16'(acc);
               acc = acc - $urandom_range(0, 1000);
            end
            SHAPE_PLATEAU: begin
               // repeated abscissas give flat spots and zero-length segments
               new_x[i] = 16'(acc);
               acc = acc + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30));
            end
            SHAPE_SCRAMBLED: begin
               new_x[i] = 16'($urandom);
            end
            default: begin
               // full-span segments with full-swing ordinates
               case ($urandom_range(0, 4))
                  0:       new_x[i] = -16'sd32768;
                  1:       new_x[i] = -16'sd32767;
                  2:       new_x[i] = 16'sd32766;
                  3:       new_x[i] = 16'sd32767;
                  default: new_x[i] = 16'sd0;
               endcase
               new_y[i] = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
            end
         endcase
      end
      for (i = 0; i < fill_n; i++)
         send_request(load_item(i, new_x[i], new_y[i]));
      for (i = 0; i < queries; i++)
         send_request(next_item(lim));
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      board        = new();
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_stall    = 1'b0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      stall_left   = 0;
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: no points in use, so every query misses
      write_point_count(7'd0);
      send_request(query_item(0));
      send_request(load_item(0, -32768, -32768));
      send_request(load_item(1, 32767, 32767));
      send_request(query_item(5));

      // a single point still has no segment
      write_point_count(7'd1);
      send_request(query_item(-32768));

      // one full-span rising segment: left end, far end, middle
      write_point_count(7'd2);
      send_request(query_item(-32768));
      send_request(query_item(32767));
      send_request(query_item(0));
      send_request(query_item(-1));

      // full-span segment with falling x and rising y
      send_request(load_item(0, 32767, -32768));
      send_request(load_item(1, -32768, 32767));
      send_request(query_item(100));
      send_request(query_item(32767));
      send_request(query_item(-32768));

      // zero-length segment hit exactly, then a point beside it
      send_request(load_item(0, 7, -5));
      send_request(load_item(1, 7, 9));
      send_request(query_item(7));
      send_request(query_item(8));

      // negative slope where the floored product rounds down
      send_request(load_item(0, 0, 10));
      send_request(load_item(1, 3, 0));
      send_request(query_item(1));

      // random phases; the first writes the whole table so no entry is unread
      run_phase(7'd64, SHAPE_RISING, 130, 1'b1, 1'b0);
      run_phase(7'd127, SHAPE_SCRAMBLED, 110, 1'b0, 1'b0);
      run_phase(7'd2, SHAPE_EXTREME, 70, 1'b0, 1'b0);
      run_phase(7'd65, SHAPE_FALLING, 110, 1'b0, 1'b0);
      run_phase(7'd1, SHAPE_SCRAMBLED, 30, 1'b0, 1'b0);
      run_phase(7'($urandom_range(3, 40)), SHAPE_PLATEAU, 110, 1'b0, 1'b0);
      run_phase(7'd0, SHAPE_RISING, 25, 1'b0, 1'b0);
      run_phase(7'd100, SHAPE_EXTREME, 90, 1'b0, 1'b0);
      run_phase(7'($urandom_range(2, 64)), SHAPE_RISING, 110, 1'b0, 1'b0);
      // closing stretch with no idling on either side
      run_phase(7'd64, SHAPE_SCRAMBLED, 130, 1'b0, 1'b1);

      @(negedge clock);
      req_valid <= 1'b0;
      while (board.expected_answers.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.failures == 0 && board.expected_answers.size() == 0) begin
         $display("piecewise_linear_interpolation_tb passed");
      end else begin
         $display("piecewise_linear_interpolation_tb failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/plin_pkg.sv
hdl/plin_ram.sv
hdl/plin_div.sv
hdl/piecewise_linear_interpolation.sv
tb/piecewise_linear_interpolation_tb.sv
